@@ hw/rtl/sssp_pkg.sv @@
// ----------------------------------------------------------------------------
// sssp_pkg
// Shared widths, operation and status codes and the controller state type of
// the single-source shortest path core.
// ----------------------------------------------------------------------------
package sssp_pkg;

  // Default sizes
  localparam int unsigned MaxVerticesDef = 64;
  localparam int unsigned MaxEdgesDef    = 256;

  // Field widths
  localparam int unsigned OpW     = 2;
  localparam int unsigned VertW   = 7;
  localparam int unsigned WeightW = 16;
  localparam int unsigned DistW   = 22;
  localparam int unsigned DistMemW = 23;
  localparam int unsigned StatW   = 2;
  localparam int unsigned InDataW  = 32;
  localparam int unsigned OutDataW = 32;

  // Operation codes
  localparam logic [OpW-1:0] OpLoad  = 2'd0;
  localparam logic [OpW-1:0] OpRun   = 2'd1;
  localparam logic [OpW-1:0] OpClear = 2'd2;

  // Status codes
  localparam logic [StatW-1:0] StOk    = 2'd0;
  localparam logic [StatW-1:0] StRange = 2'd1;
  localparam logic [StatW-1:0] StFull  = 2'd2;
  localparam logic [StatW-1:0] StRoot  = 2'd3;

  // Configuration register indexes
  localparam logic CfgVertexCount = 1'b0;
  localparam logic CfgRootVertex  = 1'b1;

  // Controller states
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MIN  = 5'b00010,
    S_EDGE = 5'b00100,
    S_ORD  = 5'b01000,
    S_OLD  = 5'b10000
  } state_e;

endpackage

@@ hw/rtl/single_source_shortest_paths_core.sv @@
// ----------------------------------------------------------------------------
// single_source_shortest_paths_core
// Edge store plus Dijkstra search over a distance memory, one result per vertex.
// ----------------------------------------------------------------------------
// Usage:
//  s_axis carries commands: tdata = op, vertex_a, vertex_b, edge_weight.
//  Load (op 0) stores an undirected edge, clear (op 2) empties the graph; each
//  gives one result beat with status, and can be taken every cycle while the
//  result side keeps up.
//  Run (op 1) searches from root_vertex and returns one beat per vertex in
//  vertex order, tlast on the final one (a bad root gives one status beat).
//  The cfg channel writes vertex_count (index 0) and root_vertex (index 1);
//  it is always ready; the user must write it only while the core is idle,
//  which the core itself does not enforce. A run does about nv rounds, each
//  a minimum scan over the distance memory and an edge sweep over the stored
//  edges, one edge per cycle, then the result beats; nv is the vertex count.
//  s_axis_tready is low for the whole run.
//  Reset sets edge count, largest weight and control registers; no memory pass.
//  A stalled m_axis holds its beat in the output register; the core waits.
// ----------------------------------------------------------------------------
module single_source_shortest_paths_core
  import sssp_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = MaxVerticesDef,
  parameter int unsigned MAX_EDGES    = MaxEdgesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // op[1:0], vertex_a[8:2], vertex_b[15:9], edge_weight[31:16]
  input  logic [InDataW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // vertex_id[6:0], distance[28:7], zero fill above
  output logic [OutDataW-1:0] m_axis_tdata,
  output logic                m_axis_tlast,
  // status[1:0]
  output logic [StatW-1:0]    m_axis_tuser,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_index_i,
  input  logic [VertW-1:0]    cfg_data_i
);

  localparam int unsigned IW = $clog2(MAX_VERTICES);
  localparam int unsigned VW = $clog2(MAX_VERTICES + 1);
  localparam int unsigned EC = $clog2(MAX_EDGES + 1);
  localparam int unsigned EA = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned EW = 2 * IW + WeightW;

  // Input fields
  logic [OpW-1:0]     in_op;
  logic [VertW-1:0]   in_a, in_b;
  logic [WeightW-1:0] in_w;
  assign in_op = s_axis_tdata[1:0];
  assign in_a  = s_axis_tdata[8:2];
  assign in_b  = s_axis_tdata[15:9];
  assign in_w  = s_axis_tdata[31:16];

  // Registers
  state_e                  st_q, st_d;
  logic [VertW-1:0]        vcount_q, root_q;
  logic [EC-1:0]           ecount_q, ecount_d;
  logic [WeightW-1:0]      lw_q, lw_d;
  logic [DistMemW-1:0]     sent_q, sent_d;
  logic [MAX_VERTICES-1:0] settled_q, settled_d;
  logic [MAX_VERTICES-1:0] dvalid_q, dvalid_d;
  logic [VW-1:0]           vcnt_q, vcnt_d, kcnt_q, kcnt_d;
  logic [EC-1:0]           ecnt_q, ecnt_d;
  logic                    pv_q, pv_d;
  logic [IW-1:0]           pidx_q, pidx_d;
  logic                    found_q, found_d;
  logic [IW-1:0]           u_q, u_d;
  logic [DistMemW-1:0]     best_q, best_d;
  logic                    ev_q, ev_d;
  logic                    rv_q, rv_d;
  logic [IW-1:0]           rn_q, rn_d;
  logic [WeightW-1:0]      rw_q, rw_d;
  logic                    wv_q, wv_d;
  logic [IW-1:0]           wn_q, wn_d;
  logic [DistMemW-1:0]     wd_q, wd_d;
  logic                    mv_q, mv_d;
  logic [VertW-1:0]        mid_q, mid_d;
  logic [DistW-1:0]        mdist_q, mdist_d;
  logic                    mlast_q, mlast_d;
  logic [StatW-1:0]        mst_q, mst_d;

  // Memories
  logic [EW-1:0]       edge_mem [MAX_EDGES];
  logic [EW-1:0]       edge_rd_q;
  logic [DistMemW-1:0] dist_mem [MAX_VERTICES];
  logic [DistMemW-1:0] dist_rd_q;

  logic                edge_we;
  logic [EW-1:0]       edge_wd;
  logic                dist_we;
  logic [IW-1:0]       dist_wa, dist_ra;
  logic [DistMemW-1:0] dist_wd;

  // Effective vertex count
  logic [VW-1:0] nv;
  always_comb begin
    if (vcount_q == '0) begin
      nv = VW'(1);
    end else if (vcount_q > VertW'(MAX_VERTICES)) begin
      nv = VW'(MAX_VERTICES);
    end else begin
      nv = VW'(vcount_q);
    end
  end

  logic in_acc, out_free;
  assign out_free      = !mv_q || m_axis_tready;
  assign s_axis_tready = (st_q == S_IDLE) && out_free;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // Edge decode in the sweep
  logic [IW-1:0]      ed_a, ed_b, ed_v;
  logic [WeightW-1:0] ed_w;
  logic               ed_rel;
  assign ed_a = edge_rd_q[EW-1 -: IW];
  assign ed_b = edge_rd_q[WeightW +: IW];
  assign ed_w = edge_rd_q[WeightW-1:0];
  assign ed_v = (ed_a == u_q) ? ed_b : ed_a;
  assign ed_rel = ev_q && (VW'(ed_a) < nv) && (VW'(ed_b) < nv)
               && ((ed_a == u_q) || (ed_b == u_q)) && !settled_q[ed_v];

  // Relax compare with forwarding of the previous cycle's write
  logic [DistMemW-1:0] cur_d, cand_d, scan_d;
  always_comb begin
    if (wv_q && (wn_q == rn_q)) begin
      cur_d = wd_q;
    end else if (dvalid_q[rn_q]) begin
      cur_d = dist_rd_q;
    end else begin
      cur_d = sent_q;
    end
  end
  assign cand_d = best_q + DistMemW'(rw_q);
  assign scan_d = dvalid_q[pidx_q] ? dist_rd_q : sent_q;

  logic [DistMemW-1:0] out_d;
  logic [IW-1:0]       out_idx;
  assign out_idx = vcnt_q[IW-1:0];
  assign out_d   = dvalid_q[out_idx] ? dist_rd_q : sent_q;

  logic in_range;
  assign in_range = (in_a != '0) && (in_a <= VertW'(nv))
                 && (in_b != '0) && (in_b <= VertW'(nv));

  // Control and datapath next state
  always_comb begin
    st_d = st_q;  ecount_d = ecount_q;  lw_d = lw_q;  sent_d = sent_q;
    settled_d = settled_q;  dvalid_d = dvalid_q;
    vcnt_d = vcnt_q;  kcnt_d = kcnt_q;  ecnt_d = ecnt_q;
    pv_d = 1'b0;  pidx_d = pidx_q;  found_d = found_q;  u_d = u_q;  best_d = best_q;
    ev_d = 1'b0;  rv_d = 1'b0;  rn_d = rn_q;  rw_d = rw_q;
    wv_d = 1'b0;  wn_d = wn_q;  wd_d = wd_q;
    mv_d = mv_q && !m_axis_tready;
    mid_d = mid_q;  mdist_d = mdist_q;  mlast_d = mlast_q;  mst_d = mst_q;
    edge_we = 1'b0;
    edge_wd = {IW'(in_a - VertW'(1)), IW'(in_b - VertW'(1)), in_w};
    dist_we = 1'b0;  dist_wa = IW'(root_q - VertW'(1));  dist_wd = '0;
    dist_ra = vcnt_q[IW-1:0];

    unique case (st_q)
      S_IDLE: begin
        if (in_acc) begin
          mid_d = '0;  mdist_d = '0;  mlast_d = 1'b1;  mst_d = StOk;
          case (in_op)
            OpLoad: begin
              mv_d = 1'b1;
              if (!in_range) begin
                mst_d = StRange;
              end else if (ecount_q == EC'(MAX_EDGES)) begin
                mst_d = StFull;
              end else begin
                edge_we  = 1'b1;
                ecount_d = ecount_q + EC'(1);
                if (in_w >= lw_q) lw_d = in_w;
              end
            end
            OpRun: begin
              if (root_q == '0 || root_q > VertW'(nv)) begin
                mv_d  = 1'b1;
                mst_d = StRoot;
              end else begin
                sent_d    = DistMemW'(nv) * DistMemW'(lw_q);
                settled_d = '0;
                dvalid_d  = '0;
                dvalid_d[dist_wa] = 1'b1;
                dist_we   = 1'b1;
                vcnt_d = '0;  kcnt_d = '0;  found_d = 1'b0;
                st_d   = S_MIN;
              end
            end
            OpClear: begin
              mv_d = 1'b1;  ecount_d = '0;  lw_d = '0;
            end
            default: ;
          endcase
        end
      end

      // Minimum scan over unsettled vertices
      S_MIN: begin
        if (pv_q && !settled_q[pidx_q] && (!found_q || scan_d < best_q)) begin
          found_d = 1'b1;  u_d = pidx_q;  best_d = scan_d;
        end
        if (vcnt_q < nv) begin
          pv_d = 1'b1;  pidx_d = vcnt_q[IW-1:0];  vcnt_d = vcnt_q + VW'(1);
        end else if (!pv_q) begin
          vcnt_d = '0;
          if (found_q) begin
            settled_d[u_q] = 1'b1;
            kcnt_d = kcnt_q + VW'(1);
            ecnt_d = '0;
            st_d   = S_EDGE;
          end else begin
            st_d = S_ORD;
          end
        end
      end

      // Edge sweep: read edge, read neighbour distance, compare and write
      S_EDGE: begin
        if (ecnt_q < ecount_q) begin
          ev_d = 1'b1;  ecnt_d = ecnt_q + EC'(1);
        end
        if (ed_rel) begin
          rv_d = 1'b1;  rn_d = ed_v;  rw_d = ed_w;
        end
        dist_ra = ed_v;
        if (rv_q && cand_d < cur_d) begin
          dist_we = 1'b1;  dist_wa = rn_q;  dist_wd = cand_d;
          dvalid_d[rn_q] = 1'b1;
          wv_d = 1'b1;  wn_d = rn_q;  wd_d = cand_d;
        end
        if (ecnt_q == ecount_q && !ev_q && !rv_q) begin
          vcnt_d  = '0;
          found_d = 1'b0;
          st_d    = (kcnt_q == nv) ? S_ORD : S_MIN;
        end
      end

      // Result read-out
      S_ORD: begin
        if (out_free) st_d = S_OLD;
      end

      S_OLD: begin
        mv_d    = 1'b1;
        mid_d   = VertW'(vcnt_q + VW'(1));
        mdist_d = out_d[DistW-1:0];
        mlast_d = (vcnt_q + VW'(1) == nv);
        mst_d   = StOk;
        vcnt_d  = vcnt_q + VW'(1);
        st_d    = mlast_d ? S_IDLE : S_ORD;
      end

      default: st_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= S_IDLE;
      vcount_q  <= VertW'(1);
      root_q    <= VertW'(1);
      ecount_q  <= '0;
      lw_q      <= '0;
      settled_q <= '0;
      dvalid_q  <= '0;
      vcnt_q    <= '0;
      kcnt_q    <= '0;
      ecnt_q    <= '0;
      pv_q      <= 1'b0;
      found_q   <= 1'b0;
      ev_q      <= 1'b0;
      rv_q      <= 1'b0;
      wv_q      <= 1'b0;
      mv_q      <= 1'b0;
    end else begin
      st_q      <= st_d;
      ecount_q  <= ecount_d;
      lw_q      <= lw_d;
      settled_q <= settled_d;
      dvalid_q  <= dvalid_d;
      vcnt_q    <= vcnt_d;
      kcnt_q    <= kcnt_d;
      ecnt_q    <= ecnt_d;
      pv_q      <= pv_d;
      found_q   <= found_d;
      ev_q      <= ev_d;
      rv_q      <= rv_d;
      wv_q      <= wv_d;
      mv_q      <= mv_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CfgVertexCount: vcount_q <= cfg_data_i;
          CfgRootVertex:  root_q   <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    sent_q  <= sent_d;
    pidx_q  <= pidx_d;
    u_q     <= u_d;
    best_q  <= best_d;
    rn_q    <= rn_d;
    rw_q    <= rw_d;
    wn_q    <= wn_d;
    wd_q    <= wd_d;
    mid_q   <= mid_d;
    mdist_q <= mdist_d;
    mlast_q <= mlast_d;
    mst_q   <= mst_d;
  end

  // Edge store
  always_ff @(posedge clk_i) begin
    if (edge_we) edge_mem[ecount_q[EA-1:0]] <= edge_wd;
    edge_rd_q <= edge_mem[ecnt_q[EA-1:0]];
  end

  // Distance table
  always_ff @(posedge clk_i) begin
    if (dist_we) dist_mem[dist_wa] <= dist_wd;
    dist_rd_q <= dist_mem[dist_ra];
  end

  // Result beat
  assign m_axis_tvalid = mv_q;
  assign m_axis_tdata  = {(OutDataW - VertW - DistW)'(0), mdist_q, mid_q};
  assign m_axis_tlast  = mlast_q;
  assign m_axis_tuser  = mst_q;

endmodule
